// ===== rtl/assert_macros.svh =====
// Assertion macros used by the deframer core RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising edge of clock outside reset.
`define ASSERT_IMPLY(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define ASSERT_IMPLY(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ===== rtl/rspdfr_pkg.sv =====
// Types, constants and helper functions of the debug packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package rspdfr_pkg;

   localparam int BUFFER_BYTES = 1024;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES);
   localparam int IDX_W        = 10;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(BUFFER_BYTES - 1);

   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] BREAK_RESET = 8'h03;

   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_DATA = 4'b0010,
      PH_HEX1 = 4'b0100,
      PH_HEX2 = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_OK      = 3'd1,
      KIND_BREAK   = 3'd2,
      KIND_ERROR   = 3'd3,
      KIND_CLOSED  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_BAD_IDLE = 3'd1,
      ERR_OVERFLOW = 3'd2,
      ERR_CLOSED   = 3'd3,
      ERR_NESTED   = 3'd4,
      ERR_BAD_HEX  = 3'd5,
      ERR_CHECKSUM = 3'd6
   } err_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       link_closed;
      logic       first_packet;
   } req_item_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       payload_byte;
      logic [IDX_W-1:0] byte_index;
      logic [IDX_W-1:0] packet_length;
      err_type          error_code;
      logic [7:0]       computed_sum;
      logic [7:0]       received_sum;
      logic             send_ack;
   } rsp_item_type;

   // Handshake status passed from the decode stage to the registers around it.
   typedef struct packed {
      logic advance;
   } stage_ctl_type;

   // Bit 4 set means the byte is not a hex digit; bits 3:0 hold the digit value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c inside {[8'h30:8'h39]}) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         v = {1'b0, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         v = {1'b0, 4'(c - 8'h37)};
      end
      return v;
   endfunction

   // Reports a count modulo 2**IDX_W, whatever the count width.
   function automatic logic [IDX_W-1:0] to_index(input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W+IDX_W-1:0] wide;
      wide = {{IDX_W{1'b0}}, cnt};
      return wide[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rspdfr_req_if.sv =====
// Input channel: one received byte or closed-link marker per word.
`timescale 1ns / 1ps
`default_nettype none

interface rspdfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       link_closed;
   logic       first_packet;

   modport source (output valid, output rx_byte, output link_closed,
                   output first_packet, input ready);
   modport sink   (input valid, input rx_byte, input link_closed,
                   input first_packet, output ready);
endinterface

`default_nettype wire

// ===== rtl/rspdfr_rsp_if.sv =====
// Result channel: one deframer event per word.
`timescale 1ns / 1ps
`default_nettype none

interface rspdfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] payload_byte;
   logic [9:0] byte_index;
   logic [9:0] packet_length;
   logic [2:0] error_code;
   logic [7:0] computed_sum;
   logic [7:0] received_sum;
   logic       send_ack;

   modport source (output valid, output kind, output payload_byte, output byte_index,
                   output packet_length, output error_code, output computed_sum,
                   output received_sum, output send_ack, input ready);
   modport sink   (input valid, input kind, input payload_byte, input byte_index,
                   input packet_length, input error_code, input computed_sum,
                   input received_sum, input send_ack, output ready);
endinterface

`default_nettype wire

// ===== rtl/rsp_packet_deframer_top.sv =====
// Top level of the debug link packet deframer.
//
//   Port group   Dir   Carries
//   req_if       in    received byte, link-closed flag, first-packet flag
//   rsp_if       out   one event: payload byte, packet ok, break, error, closed
//   csr_*        in    break character write
//
// A new word is taken every cycle while the result register does not stall.
// A word passes through the input register, then the result register.
// Words that cause no event (start, '#', first hex digit, tolerated acks) emit nothing.
// A stalled result register holds the decode stage, and the input register then fills.
// Synchronous reset returns to hunting with the break character set to 3.
`timescale 1ns / 1ps
`default_nettype none

module rsp_packet_deframer_top
   import rspdfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   rspdfr_req_if.sink      req_if,
   rspdfr_rsp_if.source    rsp_if,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0]    break_char_ff, break_char_in;
   stage_ctl_type ctl;
   logic          item_valid;
   req_item_type  item;
   logic          res_valid;
   rsp_item_type  res;
   logic          out_free;

   assign break_char_in = csr_write_enable ? csr_write_data : break_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         break_char_ff <= BREAK_RESET;
      end else begin
         break_char_ff <= break_char_in;
      end
   end

   rspdfr_inreg u_inreg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .ctl        (ctl),
      .item_valid (item_valid),
      .item       (item)
   );

   rspdfr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .break_char (break_char_ff),
      .out_free   (out_free),
      .ctl        (ctl),
      .res_valid  (res_valid),
      .res        (res)
   );

   rspdfr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

// ===== rtl/rspdfr_inreg.sv =====
// Input register stage that captures one received word.
`timescale 1ns / 1ps
`default_nettype none

module rspdfr_inreg
   import rspdfr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   rspdfr_req_if.sink         req_if,
   input  stage_ctl_type      ctl,
   output logic               item_valid,
   output req_item_type       item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         fire;

   // The register frees up in the same cycle that its word moves on.
   assign req_if.ready = !valid_ff || ctl.advance;
   assign fire         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = fire || (valid_ff && !ctl.advance);
      item_in  = item_ff;
      if (fire) begin
         item_in.rx_byte      = req_if.rx_byte;
         item_in.link_closed  = req_if.link_closed;
         item_in.first_packet = req_if.first_packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/rspdfr_core.sv =====
// Packet framing state and the per-word decode into at most one event.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rspdfr_core
   import rspdfr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   input  req_item_type       item,
   input  wire logic [7:0]    break_char,
   input  wire logic          out_free,
   output stage_ctl_type      ctl,
   output logic               res_valid,
   output rsp_item_type       res
);

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic [3:0]         nibble_ff, nibble_in;
   logic               advance;
   logic [4:0]         hex;
   logic [7:0]         rsum;
   logic               hunt_again;

   assign advance      = item_valid && out_free;
   assign ctl.advance  = advance;
   assign hex          = hex_value(item.rx_byte);
   assign rsum         = {nibble_ff, hex[3:0]};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      nibble_in  = nibble_ff;
      hunt_again = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      case (phase_ff)
         PH_HUNT: begin
            if (item.link_closed) begin
               res_valid = 1'b1;
               res.kind  = KIND_CLOSED;
            end else if (item.rx_byte == CH_DOLLAR) begin
               hunt_again = 1'b1;
               phase_in   = PH_DATA;
            end else if (item.rx_byte == break_char) begin
               res_valid = 1'b1;
               res.kind  = KIND_BREAK;
            end else if (item.first_packet &&
                         (item.rx_byte == CH_PLUS || item.rx_byte == CH_MINUS)) begin
               res_valid = 1'b0;
            end else begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_IDLE;
            end
         end
         PH_DATA: begin
            // The word after 1023 payload bytes reports an overflow, whatever it holds.
            if (count_ff == COUNT_LIMIT) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_OVERFLOW;
            end else if (item.link_closed) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_CLOSED;
            end else if (item.rx_byte == CH_HASH) begin
               phase_in = PH_HEX1;
            end else if (item.rx_byte == CH_DOLLAR) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_NESTED;
            end else begin
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = item.rx_byte;
               res.byte_index   = to_index(count_ff);
               sum_in           = sum_ff + item.rx_byte;
               count_in         = count_ff + COUNT_W'(1);
            end
         end
         PH_HEX1: begin
            if (item.link_closed) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_CLOSED;
            end else if (hex[4]) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_HEX;
            end else begin
               nibble_in = hex[3:0];
               phase_in  = PH_HEX2;
            end
         end
         PH_HEX2: begin
            hunt_again = 1'b1;
            res_valid  = 1'b1;
            if (item.link_closed) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_CLOSED;
            end else if (hex[4]) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_BAD_HEX;
            end else if (rsum == sum_ff) begin
               res.kind          = KIND_OK;
               res.packet_length = to_index(count_ff);
               res.computed_sum  = sum_ff;
               res.received_sum  = rsum;
               res.send_ack      = 1'b1;
            end else begin
               res.kind         = KIND_ERROR;
               res.error_code   = ERR_CHECKSUM;
               res.computed_sum = sum_ff;
               res.received_sum = rsum;
            end
         end
         default: begin
            hunt_again = 1'b1;
         end
      endcase

      // Every error, and every finished packet, leaves the block hunting.
      if (hunt_again || (res_valid && res.kind == KIND_ERROR)) begin
         phase_in  = (phase_ff == PH_HUNT && !item.link_closed &&
                      item.rx_byte == CH_DOLLAR) ? PH_DATA : PH_HUNT;
         count_in  = '0;
         sum_in    = '0;
         nibble_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= '0;
         sum_ff    <= '0;
         nibble_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         nibble_ff <= nibble_in;
      end
   end

   `ASSERT_NEVER(a_hunt_clean, phase_ff == PH_HUNT && (count_ff != '0 || sum_ff != '0), "state not cleared while hunting")
   `ASSERT_NEVER(a_count_limit, count_ff > COUNT_LIMIT, "payload count past buffer limit")
   `ASSERT_IMPLY(a_error_hunts, (advance && res_valid && res.kind == KIND_ERROR) |=> (phase_ff == PH_HUNT), "error did not return to hunting")
   `ASSERT_IMPLY(a_stall_holds, (item_valid && !out_free) |=> $stable(phase_ff) && $stable(count_ff), "state moved while stalled")

endmodule

`default_nettype wire

// ===== rtl/rspdfr_out.sv =====
// Result register that holds one event until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module rspdfr_out
   import rspdfr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  stage_ctl_type      ctl,
   input  wire logic          res_valid,
   input  rsp_item_type       res,
   output logic               out_free,
   rspdfr_rsp_if.source       rsp_if
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff, data_in;
   logic         load;

   assign out_free = !valid_ff || rsp_if.ready;
   assign load     = ctl.advance && res_valid;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_if.ready);
      data_in  = load ? res : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.kind          = data_ff.kind;
   assign rsp_if.payload_byte  = data_ff.payload_byte;
   assign rsp_if.byte_index    = data_ff.byte_index;
   assign rsp_if.packet_length = data_ff.packet_length;
   assign rsp_if.error_code    = data_ff.error_code;
   assign rsp_if.computed_sum  = data_ff.computed_sum;
   assign rsp_if.received_sum  = data_ff.received_sum;
   assign rsp_if.send_ack      = data_ff.send_ack;

endmodule

`default_nettype wire
